// File: rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int HUE_W  = 13;
  localparam int CH_W   = 8;
  localparam int FRAC_W = 10;
  localparam int RAW_W  = 4;

  localparam int HUE_PER_SECTOR = 960;
  localparam int UNIT_SCALE     = 255;
  localparam int FRAC_SCALE     = UNIT_SCALE * HUE_PER_SECTOR;

  // Largest sector a 13-bit hue can reach; everything from five up folds to five.
  localparam int MAX_RAW_SECTOR = 8;
  localparam int LAST_SECTOR    = 5;

  // Width of products and numerators.
  localparam int FPROD_W = CH_W + FRAC_W;   // s * f
  localparam int PNUM_W  = 2 * CH_W;        // v * (255 - s)
  localparam int QNUM_W  = CH_W + FPROD_W;  // v * (244800 - s * f)

  // Reciprocal constants: floor(2^shift / divisor), estimate low by at most one.
  localparam int RECIP_FRAC_SHIFT = 34;
  localparam int RECIP_FRAC_W     = 17;
  localparam logic [RECIP_FRAC_W-1:0] RECIP_FRAC = RECIP_FRAC_W'(70179);
  localparam int RECIP_UNIT_SHIFT = 24;
  localparam int RECIP_UNIT_W     = 17;
  localparam logic [RECIP_UNIT_W-1:0] RECIP_UNIT = RECIP_UNIT_W'(65793);

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t             sector;
    logic [FRAC_W-1:0]   frac;
  } hue_split_t;

endpackage

// File: rtl/core/hsv2rgb_hsv_if.sv
interface hsv2rgb_hsv_if;
  logic                          valid;
  logic                          ready;
  logic [hsv2rgb_pkg::HUE_W-1:0] hue;
  logic [hsv2rgb_pkg::CH_W-1:0]  saturation;
  logic [hsv2rgb_pkg::CH_W-1:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// File: rtl/core/hsv2rgb_rgb_if.sv
interface hsv2rgb_rgb_if;
  logic                         valid;
  logic                         ready;
  logic [hsv2rgb_pkg::CH_W-1:0] red;
  logic [hsv2rgb_pkg::CH_W-1:0] green;
  logic [hsv2rgb_pkg::CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: rtl/core/hsv2rgb_sector.sv
module hsv2rgb_sector (
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
  output hsv2rgb_pkg::hue_split_t        split
);

  logic [hsv2rgb_pkg::RAW_W-1:0] raw;
  logic [hsv2rgb_pkg::HUE_W-1:0] base;

  // Independent threshold compares; the highest one passed gives the sector.
  always_comb begin
    raw = '0;
    for (int k = 1; k <= hsv2rgb_pkg::MAX_RAW_SECTOR; k++) begin
      if (hue >= hsv2rgb_pkg::HUE_W'(k * hsv2rgb_pkg::HUE_PER_SECTOR)) begin
        raw = hsv2rgb_pkg::RAW_W'(k);
      end
    end
    base = hsv2rgb_pkg::HUE_W'(32'(raw) * hsv2rgb_pkg::HUE_PER_SECTOR);
    split.frac = hsv2rgb_pkg::FRAC_W'(hue - base);
    // Out-of-range hue keeps its fraction but uses the last sector's mapping.
    if (raw >= hsv2rgb_pkg::RAW_W'(hsv2rgb_pkg::LAST_SECTOR)) begin
      split.sector = hsv2rgb_pkg::SEC_MR;
    end else begin
      split.sector = hsv2rgb_pkg::sector_t'(raw[2:0]);
    end
  end

endmodule

// File: rtl/core/hsv_to_rgb_converter_top.sv
// Channel    Dir  Fields                           Transfer
// pixel_in   in   hue[12:0] saturation brightness  valid && ready
// pixel_out  out  red green blue                   valid && ready
//
// Six register stages: sector split, s*f products, v*numerator products,
// reciprocal estimates, estimate*divisor products, correction and RGB select.
// One pixel per cycle sustained while pixel_out is ready.
// rst clears every stage valid bit; payload registers are not reset.
// A stall at pixel_out holds only the stages that are full; bubbles still fill.
module hsv_to_rgb_converter_top (
  input  logic                 clk,
  input  logic                 rst,
  hsv2rgb_hsv_if.sink          pixel_in,
  hsv2rgb_rgb_if.source        pixel_out
);

  localparam int NSTAGE = 6;
  localparam int QNUM_PROD_W = hsv2rgb_pkg::QNUM_W + hsv2rgb_pkg::RECIP_FRAC_W;
  localparam int PNUM_PROD_W = hsv2rgb_pkg::PNUM_W + hsv2rgb_pkg::RECIP_UNIT_W;

  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] adv;

  // Stage 1
  hsv2rgb_pkg::hue_split_t              split;
  hsv2rgb_pkg::sector_t                 sec1;
  logic [hsv2rgb_pkg::FRAC_W-1:0]       frac1;
  logic [hsv2rgb_pkg::CH_W-1:0]         sat1;
  logic [hsv2rgb_pkg::CH_W-1:0]         val1;

  // Stage 2
  hsv2rgb_pkg::sector_t                 sec2;
  logic [hsv2rgb_pkg::CH_W-1:0]         val2;
  logic                                 grey2;
  logic [hsv2rgb_pkg::FPROD_W-1:0]      sfq2;
  logic [hsv2rgb_pkg::FPROD_W-1:0]      sft2;
  logic [hsv2rgb_pkg::PNUM_W-1:0]       pnum2;

  // Stage 3
  hsv2rgb_pkg::sector_t                 sec3;
  logic [hsv2rgb_pkg::CH_W-1:0]         val3;
  logic                                 grey3;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       qnum3;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       tnum3;
  logic [hsv2rgb_pkg::PNUM_W-1:0]       pnum3;

  // Stage 4
  hsv2rgb_pkg::sector_t                 sec4;
  logic [hsv2rgb_pkg::CH_W-1:0]         val4;
  logic                                 grey4;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       qnum4;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       tnum4;
  logic [hsv2rgb_pkg::PNUM_W-1:0]       pnum4;
  logic [hsv2rgb_pkg::CH_W-1:0]         qest4;
  logic [hsv2rgb_pkg::CH_W-1:0]         test4;
  logic [hsv2rgb_pkg::CH_W-1:0]         pest4;

  // Stage 5
  hsv2rgb_pkg::sector_t                 sec5;
  logic [hsv2rgb_pkg::CH_W-1:0]         val5;
  logic                                 grey5;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       qnum5;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       tnum5;
  logic [hsv2rgb_pkg::PNUM_W-1:0]       pnum5;
  logic [hsv2rgb_pkg::CH_W-1:0]         qest5;
  logic [hsv2rgb_pkg::CH_W-1:0]         test5;
  logic [hsv2rgb_pkg::CH_W-1:0]         pest5;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       qback5;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       tback5;
  logic [hsv2rgb_pkg::PNUM_W-1:0]       pback5;

  // Stage 6 (output)
  logic [hsv2rgb_pkg::CH_W-1:0]         red;
  logic [hsv2rgb_pkg::CH_W-1:0]         green;
  logic [hsv2rgb_pkg::CH_W-1:0]         blue;

  // Combinational helpers
  logic [hsv2rgb_pkg::FRAC_W-1:0]       cofrac;
  logic [QNUM_PROD_W-1:0]               qprod;
  logic [QNUM_PROD_W-1:0]               tprod;
  logic [PNUM_PROD_W-1:0]               pprod;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       qrem;
  logic [hsv2rgb_pkg::QNUM_W-1:0]       trem;
  logic [hsv2rgb_pkg::PNUM_W-1:0]       prem;
  logic [hsv2rgb_pkg::CH_W-1:0]         qv;
  logic [hsv2rgb_pkg::CH_W-1:0]         tv;
  logic [hsv2rgb_pkg::CH_W-1:0]         pv;
  logic [hsv2rgb_pkg::CH_W-1:0]         red_next;
  logic [hsv2rgb_pkg::CH_W-1:0]         green_next;
  logic [hsv2rgb_pkg::CH_W-1:0]         blue_next;

  hsv2rgb_sector u_sector (
    .hue   (pixel_in.hue),
    .split (split)
  );

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[NSTAGE] = !vld[NSTAGE] || pixel_out.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pixel_in.ready  = adv[1];
  assign pixel_out.valid = vld[NSTAGE];
  assign pixel_out.red   = red;
  assign pixel_out.green = green;
  assign pixel_out.blue  = blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= pixel_in.valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign cofrac = hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::HUE_PER_SECTOR - 32'(frac1));

  // Stage 1: split hue into sector and fraction.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sec1  <= split.sector;
      frac1 <= split.frac;
      sat1  <= pixel_in.saturation;
      val1  <= pixel_in.brightness;
    end
  end

  // Stage 2: s*f, s*(960-f), v*(255-s).
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sec2  <= sec1;
      val2  <= val1;
      grey2 <= (sat1 == '0);
      sfq2  <= hsv2rgb_pkg::FPROD_W'(sat1) * hsv2rgb_pkg::FPROD_W'(frac1);
      sft2  <= hsv2rgb_pkg::FPROD_W'(sat1) * hsv2rgb_pkg::FPROD_W'(cofrac);
      pnum2 <= hsv2rgb_pkg::PNUM_W'(val1) *
               hsv2rgb_pkg::PNUM_W'(hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::UNIT_SCALE) - sat1);
    end
  end

  // Stage 3: numerators for q and t.
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sec3  <= sec2;
      val3  <= val2;
      grey3 <= grey2;
      pnum3 <= pnum2;
      qnum3 <= hsv2rgb_pkg::QNUM_W'(val2) *
               hsv2rgb_pkg::QNUM_W'(hsv2rgb_pkg::FPROD_W'(hsv2rgb_pkg::FRAC_SCALE) - sfq2);
      tnum3 <= hsv2rgb_pkg::QNUM_W'(val2) *
               hsv2rgb_pkg::QNUM_W'(hsv2rgb_pkg::FPROD_W'(hsv2rgb_pkg::FRAC_SCALE) - sft2);
    end
  end

  // Stage 4: reciprocal quotient estimates, low by at most one.
  assign qprod = QNUM_PROD_W'(qnum3) * QNUM_PROD_W'(hsv2rgb_pkg::RECIP_FRAC);
  assign tprod = QNUM_PROD_W'(tnum3) * QNUM_PROD_W'(hsv2rgb_pkg::RECIP_FRAC);
  assign pprod = PNUM_PROD_W'(pnum3) * PNUM_PROD_W'(hsv2rgb_pkg::RECIP_UNIT);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sec4  <= sec3;
      val4  <= val3;
      grey4 <= grey3;
      qnum4 <= qnum3;
      tnum4 <= tnum3;
      pnum4 <= pnum3;
      qest4 <= qprod[hsv2rgb_pkg::RECIP_FRAC_SHIFT +: hsv2rgb_pkg::CH_W];
      test4 <= tprod[hsv2rgb_pkg::RECIP_FRAC_SHIFT +: hsv2rgb_pkg::CH_W];
      pest4 <= pprod[hsv2rgb_pkg::RECIP_UNIT_SHIFT +: hsv2rgb_pkg::CH_W];
    end
  end

  // Stage 5: multiply estimates back by the divisors.
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      sec5   <= sec4;
      val5   <= val4;
      grey5  <= grey4;
      qnum5  <= qnum4;
      tnum5  <= tnum4;
      pnum5  <= pnum4;
      qest5  <= qest4;
      test5  <= test4;
      pest5  <= pest4;
      qback5 <= hsv2rgb_pkg::QNUM_W'(qest4) * hsv2rgb_pkg::QNUM_W'(hsv2rgb_pkg::FRAC_SCALE);
      tback5 <= hsv2rgb_pkg::QNUM_W'(test4) * hsv2rgb_pkg::QNUM_W'(hsv2rgb_pkg::FRAC_SCALE);
      pback5 <= hsv2rgb_pkg::PNUM_W'(pest4) * hsv2rgb_pkg::PNUM_W'(hsv2rgb_pkg::UNIT_SCALE);
    end
  end

  // Stage 6: bump estimates whose remainder reaches the divisor, then select.
  always_comb begin
    qrem = qnum5 - qback5;
    trem = tnum5 - tback5;
    prem = pnum5 - pback5;
    qv = qest5 + hsv2rgb_pkg::CH_W'(qrem >= hsv2rgb_pkg::QNUM_W'(hsv2rgb_pkg::FRAC_SCALE));
    tv = test5 + hsv2rgb_pkg::CH_W'(trem >= hsv2rgb_pkg::QNUM_W'(hsv2rgb_pkg::FRAC_SCALE));
    pv = pest5 + hsv2rgb_pkg::CH_W'(prem >= hsv2rgb_pkg::PNUM_W'(hsv2rgb_pkg::UNIT_SCALE));
    red_next   = val5;
    green_next = pv;
    blue_next  = qv;
    if (grey5) begin
      red_next   = val5;
      green_next = val5;
      blue_next  = val5;
    end else begin
      unique case (sec5)
        hsv2rgb_pkg::SEC_RY: begin
          red_next = val5; green_next = tv;   blue_next = pv;
        end
        hsv2rgb_pkg::SEC_YG: begin
          red_next = qv;   green_next = val5; blue_next = pv;
        end
        hsv2rgb_pkg::SEC_GC: begin
          red_next = pv;   green_next = val5; blue_next = tv;
        end
        hsv2rgb_pkg::SEC_CB: begin
          red_next = pv;   green_next = qv;   blue_next = val5;
        end
        hsv2rgb_pkg::SEC_BM: begin
          red_next = tv;   green_next = pv;   blue_next = val5;
        end
        default: begin
          red_next = val5; green_next = pv;   blue_next = qv;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule
